@@ hw/rtl/chs_pkg.sv @@
// ----------------------------------------------------------------------------
// chs_pkg
// Shared constants and types for the cone hit scorer.
// ----------------------------------------------------------------------------
package chs_pkg;

    localparam int MAX_SENSORS = 2048;
    localparam int ADDR_W      = $clog2(MAX_SENSORS);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int POS_W       = 15;
    localparam int SCORE_W     = 14;
    localparam int ENTRY_W     = 3 * POS_W + 1;
    localparam int PIPE_N      = 7;

    // configuration register indexes
    localparam logic [2:0] REG_REF_X   = 3'd0;
    localparam logic [2:0] REG_REF_Y   = 3'd1;
    localparam logic [2:0] REG_REF_Z   = 3'd2;
    localparam logic [2:0] REG_COUNT   = 3'd3;
    localparam logic [2:0] REG_RADIUS  = 3'd4;
    localparam logic [2:0] REG_COSINE  = 3'd5;

    // input op codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [13:0] RADIUS_RST = 14'd9000;
    localparam logic [15:0] COSINE_RST = 16'd24638;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RDT   = 8'b0000_0010,
        S_TA    = 8'b0000_0100,
        S_TB    = 8'b0000_1000,
        S_TC    = 8'b0001_0000,
        S_SCAN  = 8'b0010_0000,
        S_DRAIN = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

endpackage

@@ hw/rtl/cone_hit_scorer_core.sv @@
// ----------------------------------------------------------------------------
// cone_hit_scorer_core
// Sensor table with a one-entry-per-cycle cone scoring scan.
// ----------------------------------------------------------------------------
// Load: the entry is written to the sensor table RAM on transfer.
// Query: for an effective count N, one table read per cycle on the single
//   RAM port sets the scan, the 7-stage compare pipe the tail.
// Out-of-range or degenerate queries answer with score 0.
// Reset (synchronous, active low) clears control, reference and count, and
// sets radius and cosine to their defaults; the table is undefined.
module cone_hit_scorer_core
    import chs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // index[10:0], pos_x[25:11], pos_y[40:26], pos_z[55:41], hit[56]
    input  logic [63:0] s_axis_tdata,
    // op[0]
    input  logic        s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // score[13:0], test_index[24:14]
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data
);

    // configuration
    logic signed [POS_W-1:0] r_ref_x, r_ref_y, r_ref_z;
    logic [CNT_W-1:0]        r_count;
    logic [13:0]             r_radius;
    logic [15:0]             r_cosine;

    t_state r_state, n_state;

    logic [ENTRY_W-1:0] r_mem [MAX_SENSORS];
    logic [ENTRY_W-1:0] r_rd;
    logic [ADDR_W-1:0]  n_addr;

    logic [ADDR_W-1:0]  r_idx;
    logic [CNT_W-1:0]   r_n, r_k;
    logic signed [SCORE_W-1:0] r_score;

    // test sensor setup
    logic signed [POS_W-1:0] r_tx, r_ty, r_tz;
    logic signed [15:0]      r_ax, r_ay, r_az;
    logic signed [31:0]      r_sax, r_say, r_saz;
    logic signed [29:0]      r_stx, r_sty, r_stz;
    logic [31:0]             r_m1, r_cc2;
    logic [27:0]             r_rr;

    // scan pipe
    logic [PIPE_N-1:0]       r_pv;
    logic                    issue, in_xfer, out_xfer;
    logic signed [15:0]      r_bx, r_by, r_bz;
    logic signed [POS_W-1:0] r_px, r_py, r_pz;
    logic [5:0]              r_hit;
    logic signed [31:0]      r_dx, r_dy, r_dz, r_qx, r_qy, r_qz;
    logic signed [29:0]      r_ox, r_oy, r_oz;
    logic signed [33:0]      c_d;
    logic [31:0]             c_m2, c_m1;
    logic [30:0]             c_r2, c_r2t;
    logic                    r_ok_c, r_ok_d, r_ok_e, r_ok_f;
    logic [30:0]             r_d;
    logic [29:0]             r_m2;
    logic [61:0]             r_d2, r_d2e, r_mm;
    logic [62:0]             r_plo, r_phi;
    logic [93:0]             c_rhs, c_lhs;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;
    assign issue         = (r_state == S_SCAN);

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x  <= '0;
            r_ref_y  <= '0;
            r_ref_z  <= '0;
            r_count  <= '0;
            r_radius <= RADIUS_RST;
            r_cosine <= COSINE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                REG_REF_X:  r_ref_x  <= i_cfg_data[POS_W-1:0];
                REG_REF_Y:  r_ref_y  <= i_cfg_data[POS_W-1:0];
                REG_REF_Z:  r_ref_z  <= i_cfg_data[POS_W-1:0];
                REG_COUNT:  r_count  <= i_cfg_data[CNT_W-1:0];
                REG_RADIUS: r_radius <= i_cfg_data[13:0];
                REG_COSINE: r_cosine <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sensor table: write on load transfer, registered read
    assign n_addr = issue ? r_k[ADDR_W-1:0] : r_idx;

    always_ff @(posedge i_clk) begin
        if (in_xfer && s_axis_tuser == OP_LOAD) begin
            r_mem[s_axis_tdata[ADDR_W-1:0]] <= s_axis_tdata[56:11];
        end
        r_rd <= r_mem[n_addr];
    end

    // sequencer
    assign c_m1  = 32'(r_sax[30:0]) + 32'(r_say[30:0]) + 32'(r_saz[30:0]);
    assign c_r2t = 31'(r_stx[28:0]) + 31'(r_sty[28:0]) + 31'(r_stz[28:0]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && s_axis_tuser == OP_QUERY) begin
                    n_state = S_RDT;
                end
            end
            S_RDT: begin
                if (CNT_W'(r_idx) < r_n) begin
                    n_state = S_TA;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_TA: n_state = S_TB;
            S_TB: n_state = S_TC;
            S_TC: begin
                if (c_m1 != '0 && c_r2t < 31'(r_rr)) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (r_k == r_n - 1'b1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_pv == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_axis_tvalid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= '0;
        end else begin
            r_state <= n_state;
            r_pv    <= {r_pv[PIPE_N-2:0], issue};
        end
    end

    // capture query, count scan, accumulate score
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_idx <= s_axis_tdata[ADDR_W-1:0];
            r_n   <= (r_count > CNT_W'(MAX_SENSORS)) ? CNT_W'(MAX_SENSORS) : r_count;
        end
        if (r_state == S_RDT) begin
            r_score <= '0;
        end else if (r_ok_f) begin
            r_score <= r_score + (r_hit[5] ? SCORE_W'(1) : -SCORE_W'(4));
        end
        if (r_state == S_TC) begin
            r_k <= '0;
        end else if (issue) begin
            r_k <= r_k + 1'b1;
        end
    end

    // test sensor: axis toward reference, squares, limits
    always_ff @(posedge i_clk) begin
        if (r_state == S_TA) begin
            r_tx <= r_rd[POS_W-1:0];
            r_ty <= r_rd[2*POS_W-1:POS_W];
            r_tz <= r_rd[3*POS_W-1:2*POS_W];
            r_ax <= 16'(r_ref_x) - 16'(signed'(r_rd[POS_W-1:0]));
            r_ay <= 16'(r_ref_y) - 16'(signed'(r_rd[2*POS_W-1:POS_W]));
            r_az <= 16'(r_ref_z) - 16'(signed'(r_rd[3*POS_W-1:2*POS_W]));
        end
        if (r_state == S_TB) begin
            r_sax <= r_ax * r_ax;
            r_say <= r_ay * r_ay;
            r_saz <= r_az * r_az;
            r_stx <= r_tx * r_tx;
            r_sty <= r_ty * r_ty;
            r_stz <= r_tz * r_tz;
            r_cc2 <= r_cosine * r_cosine;
            r_rr  <= r_radius * r_radius;
        end
        if (r_state == S_TC) begin
            r_m1 <= c_m1;
        end
    end

    // scan stage A: offsets from the test sensor
    always_ff @(posedge i_clk) begin
        r_px  <= r_rd[POS_W-1:0];
        r_py  <= r_rd[2*POS_W-1:POS_W];
        r_pz  <= r_rd[3*POS_W-1:2*POS_W];
        r_bx  <= 16'(signed'(r_rd[POS_W-1:0])) - 16'(r_tx);
        r_by  <= 16'(signed'(r_rd[2*POS_W-1:POS_W])) - 16'(r_ty);
        r_bz  <= 16'(signed'(r_rd[3*POS_W-1:2*POS_W])) - 16'(r_tz);
        r_hit <= {r_hit[4:0], r_rd[ENTRY_W-1]};
    end

    // stage B: dot terms and squares
    always_ff @(posedge i_clk) begin
        r_dx <= r_ax * r_bx;
        r_dy <= r_ay * r_by;
        r_dz <= r_az * r_bz;
        r_qx <= r_bx * r_bx;
        r_qy <= r_by * r_by;
        r_qz <= r_bz * r_bz;
        r_ox <= r_px * r_px;
        r_oy <= r_py * r_py;
        r_oz <= r_pz * r_pz;
    end

    // stage C: sums and the cheap rejections
    assign c_d  = 34'(r_dx) + 34'(r_dy) + 34'(r_dz);
    assign c_m2 = 32'(r_qx[30:0]) + 32'(r_qy[30:0]) + 32'(r_qz[30:0]);
    assign c_r2 = 31'(r_ox[28:0]) + 31'(r_oy[28:0]) + 31'(r_oz[28:0]);

    always_ff @(posedge i_clk) begin
        r_ok_c <= r_pv[2] && c_m2 != '0 && c_r2 < 31'(r_rr) && c_d > 34'sd0;
        r_d    <= c_d[30:0];
        r_m2   <= c_m2[29:0];
    end

    // stage D: d squared and |v1|^2 |v2|^2
    always_ff @(posedge i_clk) begin
        r_ok_d <= r_ok_c;
        r_d2   <= r_d * r_d;
        r_mm   <= r_m1 * r_m2;
    end

    // stage E: cosine squared times the magnitude product, in two halves
    always_ff @(posedge i_clk) begin
        r_ok_e <= r_ok_d;
        r_d2e  <= r_d2;
        r_plo  <= r_cc2 * r_mm[30:0];
        r_phi  <= r_cc2 * r_mm[61:31];
    end

    // stage F: strict angle compare
    assign c_rhs = {r_phi, 31'b0} + 94'(r_plo);
    assign c_lhs = {2'b0, r_d2e, 30'b0};

    always_ff @(posedge i_clk) begin
        r_ok_f <= r_ok_e && (c_lhs > c_rhs);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (r_state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
            m_axis_tvalid <= 1'b1;
        end else if (out_xfer) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
            m_axis_tdata <= {7'b0, r_idx, r_score};
        end
    end

    // checks
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_pv == '0)
        else $error("scan pipe busy while idle");

    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |=> r_state == S_SCAN || r_state == S_DRAIN)
        else $error("scan left without drain");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_DONE))
        else $error("result raised outside done");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && s_axis_tuser == OP_LOAD |-> r_pv == '0)
        else $error("table written during scan");

endmodule

@@ verif/cone_hit_scorer_core_tb.sv @@
// ----------------------------------------------------------------------------
// cone_hit_scorer_core_tb
// Self-checking bench: loads sensor entries, sets up the reference point,
// radius and cone, runs score queries and checks every score against an
// integer cone-test predictor kept inside the bench. Both stream sides idle
// at random and the score side holds off for a long stretch once.
// ----------------------------------------------------------------------------
module cone_hit_scorer_core_tb;
    import chs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 30;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [ADDR_W-1:0]         test_index;
    } t_score;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_addr = '0;
    logic [15:0] i_cfg_data = '0;

    // Predictor state: sensor table and register copies
    int          pos_x_tab [MAX_SENSORS];
    int          pos_y_tab [MAX_SENSORS];
    int          pos_z_tab [MAX_SENSORS];
    bit          hit_tab   [MAX_SENSORS];
    int          apex_x, apex_y, apex_z;
    int unsigned count_reg, radius_reg, cosine_reg;

    t_score      pending_scores[$];
    bit          gaps_on = 1'b1;
    int          hold_cycles = 0;
    int          stall_left = 0;
    int          mismatches = 0;
    int          cycles = 0;
    int          n_loads = 0, n_queries = 0, n_nonzero = 0, n_checked = 0;

    cone_hit_scorer_core dut (.*);

    always #5 i_clk = ~i_clk;

    // Abort on a stuck run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d scores pending", cycles,
                     pending_scores.size());
            $display("[cone_hit_scorer_core] ERROR");
            $finish;
        end
    end

    // Score-side ready: random stalls per transfer, long hold on request
    always @(posedge i_clk) begin
        int s;
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            s = gaps_on ? $urandom_range(0, 5) : 0;
            stall_left <= s;
            m_axis_tready <= (s == 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each score transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_score got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.score      = m_axis_tdata[13:0];
            got.test_index = m_axis_tdata[24:14];
            if (pending_scores.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected score %0d for index %0d", got.score,
                             got.test_index);
            end else begin
                want = pending_scores.pop_front();
                n_checked++;
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("score mismatch: expected %0d/idx %0d, got %0d/idx %0d",
                                 want.score, want.test_index, got.score,
                                 got.test_index);
                end
            end
        end
    end

    function automatic bit in_radius(longint x, longint y, longint z);
        longint unsigned r;
        r = radius_reg;
        return longint'(x * x + y * y + z * z) < r * r;
    endfunction

    // Cone score of one test sensor against the first count entries
    function automatic t_score cone_score(int unsigned t);
        longint          tx, ty, tz, ax, ay, az, bx, by, bz, d;
        longint unsigned m1, m2, cc2, du;
        logic [127:0]    lhs, rhs;
        int              acc, n;
        t_score          res;
        n = (count_reg > MAX_SENSORS) ? MAX_SENSORS : count_reg;
        acc = 0;
        if (t < n) begin
            tx = pos_x_tab[t]; ty = pos_y_tab[t]; tz = pos_z_tab[t];
            ax = apex_x - tx; ay = apex_y - ty; az = apex_z - tz;
            m1 = ax * ax + ay * ay + az * az;
            if (m1 != 0 && in_radius(tx, ty, tz)) begin
                cc2 = longint'(cosine_reg) * cosine_reg;
                for (int k = 0; k < n; k++) begin
                    bx = pos_x_tab[k] - tx; by = pos_y_tab[k] - ty; bz = pos_z_tab[k] - tz;
                    m2 = bx * bx + by * by + bz * bz;
                    if (m2 == 0 || !in_radius(pos_x_tab[k], pos_y_tab[k], pos_z_tab[k]))
                        continue;
                    d = ax * bx + ay * by + az * bz;
                    if (d <= 0)
                        continue;
                    du  = d;
                    lhs = {64'd0, du * du} << 30;
                    rhs = {64'd0, cc2} * {64'd0, m1 * m2};
                    if (lhs > rhs)
                        acc += hit_tab[k] ? 1 : -4;
                end
            end
        end
        if (acc > 8191) acc = 8191;
        if (acc < -8192) acc = -8192;
        res.score = acc[13:0];
        res.test_index = t[ADDR_W-1:0];
        return res;
    endfunction

    // Offer one item, hold valid until the transfer, then predict
    task automatic send_item(logic op, int idx, int x, int y, int z, bit hit);
        int gap;
        logic [14:0] px, py, pz;
        logic [10:0] ix;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        px = x[14:0]; py = y[14:0]; pz = z[14:0]; ix = idx[10:0];
        s_axis_tdata  <= {7'd0, hit, pz, py, px, ix};
        s_axis_tuser  <= op;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == OP_LOAD) begin
            pos_x_tab[ix] = $signed(px);
            pos_y_tab[ix] = $signed(py);
            pos_z_tab[ix] = $signed(pz);
            hit_tab[ix]   = hit;
            n_loads++;
        end else begin
            pending_scores.push_back(cone_score(ix));
            n_queries++;
            if (pending_scores[$].score != 0) n_nonzero++;
        end
    endtask

    task automatic load(int idx, int x, int y, int z, bit hit);
        send_item(OP_LOAD, idx, x, y, z, hit);
    endtask

    task automatic query(int idx);
        send_item(OP_QUERY, idx, 0, 0, 0, 1'b0);
    endtask

    // Drop valid and wait until every score has come back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, int value);
        i_cfg_addr  <= addr;
        i_cfg_data  <= value[15:0];
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (addr)
            REG_REF_X:  apex_x = $signed(value[14:0]);
            REG_REF_Y:  apex_y = $signed(value[14:0]);
            REG_REF_Z:  apex_z = $signed(value[14:0]);
            REG_COUNT:  count_reg = value[11:0];
            REG_RADIUS: radius_reg = value[13:0];
            REG_COSINE: cosine_reg = value[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic int near_pos();
        return int'($urandom_range(0, 4000)) - 2000;
    endfunction

    function automatic int any_pos();
        return int'($urandom_range(0, 32767)) - 16384;
    endfunction

    function automatic int pick_pos();
        return ($urandom_range(0, 9) == 0) ? any_pos() : near_pos();
    endfunction

    // Extremes, degenerate test sensors, out-of-count and cosine corners
    task automatic test_directed();
        load(0, 0, 0, 0, 1);
        load(1, 16383, 16383, 16383, 0);
        load(2, -16384, -16384, -16384, 1);
        load(3, 100, 0, 0, 1);
        load(4, 200, 10, 0, 1);
        load(5, 300, -20, 5, 0);
        load(6, 100, 0, 0, 0);
        load(7, -500, 0, 0, 1);
        wait_idle();
        write_reg(REG_COUNT, 8);
        for (int i = 0; i < 8; i++) query(i);
        query(8);
        query(2047);
        wait_idle();
        write_reg(REG_REF_X, 16383);
        write_reg(REG_REF_Y, -16384);
        write_reg(REG_REF_Z, 0);
        query(4);
        query(7);
        wait_idle();
        write_reg(REG_REF_X, 0);
        write_reg(REG_REF_Y, 0);
        write_reg(REG_COSINE, 0);
        query(5);
        wait_idle();
        write_reg(REG_COSINE, 32768);
        query(5);
        wait_idle();
        write_reg(REG_COSINE, 65535);
        query(5);
        wait_idle();
        write_reg(REG_RADIUS, 0);
        query(3);
        wait_idle();
        write_reg(REG_RADIUS, 16383);
        write_reg(REG_COSINE, 30000);
        query(1);
        query(7);
        wait_idle();
    endtask

    // Random settings, loads over the first 64 entries, and queries, some out of range
    task automatic test_random(int phases, int per_phase);
        int cnt;
        for (int i = 0; i < 64; i++)
            load(i, near_pos(), near_pos(), near_pos(), $urandom_range(0, 1));
        for (int p = 0; p < phases; p++) begin
            wait_idle();
            gaps_on = ($urandom_range(0, 3) != 0);
            cnt = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 64);
            write_reg(REG_REF_X, ($urandom_range(0, 4) == 0) ? any_pos() : near_pos());
            write_reg(REG_REF_Y, ($urandom_range(0, 4) == 0) ? any_pos() : near_pos());
            write_reg(REG_REF_Z, ($urandom_range(0, 4) == 0) ? any_pos() : near_pos());
            write_reg(REG_COUNT, cnt);
            case ($urandom_range(0, 5))
                0: write_reg(REG_RADIUS, 0);
                1: write_reg(REG_RADIUS, 16383);
                default: write_reg(REG_RADIUS, $urandom_range(1500, 12000));
            endcase
            case ($urandom_range(0, 7))
                0: write_reg(REG_COSINE, 0);
                1: write_reg(REG_COSINE, 32768);
                2: write_reg(REG_COSINE, $urandom_range(32769, 65535));
                default: write_reg(REG_COSINE, $urandom_range(15000, 32768));
            endcase
            for (int j = 0; j < per_phase; j++) begin
                if ($urandom_range(0, 9) < 6)
                    load($urandom_range(0, 63), pick_pos(), pick_pos(), pick_pos(),
                         $urandom_range(0, 1));
                else if ($urandom_range(0, 9) == 0)
                    query($urandom_range(0, 2047));
                else
                    query($urandom_range(0, (cnt > 0) ? cnt - 1 : 0));
            end
        end
        wait_idle();
    endtask

    // Hold the score side off while queries keep arriving
    task automatic test_backpressure();
        gaps_on = 1'b0;
        write_reg(REG_COUNT, 16);
        write_reg(REG_RADIUS, 9000);
        write_reg(REG_COSINE, 24638);
        hold_cycles <= 400;
        for (int i = 0; i < 10; i++) query($urandom_range(0, 15));
        wait_idle();
        gaps_on = 1'b1;
    endtask

    initial begin
        apex_x = 0; apex_y = 0; apex_z = 0;
        count_reg = 0;
        radius_reg = RADIUS_RST;
        cosine_reg = COSINE_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (5) @(posedge i_clk);

        test_directed();
        test_random(5, 40);
        test_backpressure();

        wait_idle();
        $display("ran %0d loads and %0d queries, %0d scores checked (%0d nonzero)",
                 n_loads, n_queries, n_checked, n_nonzero);
        $display("covered ref/radius/cosine extremes, empty and partial counts, back-pressure");
        if (mismatches == 0 && pending_scores.size() == 0) begin
            $display("[cone_hit_scorer_core] OK");
        end else begin
            $display("%0d mismatches, %0d scores missing", mismatches, pending_scores.size());
            $display("[cone_hit_scorer_core] ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/chs_pkg.sv
hw/rtl/cone_hit_scorer_core.sv
verif/cone_hit_scorer_core_tb.sv
